// File: rtl/core/lobm_pkg.sv
// Shared types, codes and widths for the order book matcher.
package lobm_pkg;
   localparam int BOOK_DEPTH_DEFAULT = 32;
   localparam int ID_W    = 32;
   localparam int PRICE_W = 16;
   localparam int QTY_W   = 24;

   localparam logic SIDE_BUY     = 1'b0;
   localparam logic SIDE_SELL    = 1'b1;
   localparam logic ORDER_LIMIT  = 1'b1;
   localparam logic ORDER_MARKET = 1'b0;
   localparam logic KIND_TRADE   = 1'b0;
   localparam logic KIND_DONE    = 1'b1;

   localparam logic [1:0] OUTCOME_FILLED  = 2'd0;
   localparam logic [1:0] OUTCOME_RESTED  = 2'd1;
   localparam logic [1:0] OUTCOME_DROPPED = 2'd2;
   localparam logic [1:0] OUTCOME_FULL    = 2'd3;

   typedef struct packed {
      logic               fill;     // take amount off the front, pop if emptied
      logic [QTY_W-1:0]   amount;
      logic               insert;
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } book_cmd_type;

   typedef struct packed {
      logic load;
      logic fill;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic qty_zero;
      logic opp_empty;
      logic price_ok;
      logic out_free;
   } dp_status_type;
endpackage

// File: rtl/core/lobm_book.sv
// One side of the book: sorted entries held in a shift line.
module lobm_book #(
   parameter int DEPTH  = lobm_pkg::BOOK_DEPTH_DEFAULT,
   parameter bit IS_BID = 1'b1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lobm_pkg::book_cmd_type        cmd,
   output logic [lobm_pkg::ID_W-1:0]     front_id,
   output logic [lobm_pkg::PRICE_W-1:0]  front_price,
   output logic [lobm_pkg::QTY_W-1:0]    front_qty,
   output logic                          empty,
   output logic                          full
);
   import lobm_pkg::*;
   localparam int CW = $clog2(DEPTH + 1);

   logic [ID_W-1:0]    ids_ff   [DEPTH];
   logic [ID_W-1:0]    ids_in   [DEPTH];
   logic [PRICE_W-1:0] prices_ff[DEPTH];
   logic [PRICE_W-1:0] prices_in[DEPTH];
   logic [QTY_W-1:0]   qtys_ff  [DEPTH];
   logic [QTY_W-1:0]   qtys_in  [DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic [DEPTH-1:0]   keep;
   logic [QTY_W-1:0]   front_left;

   assign front_id    = ids_ff[0];
   assign front_price = prices_ff[0];
   assign front_qty   = qtys_ff[0];
   assign empty       = (count_ff == '0);
   assign full        = (count_ff == CW'(DEPTH));
   assign front_left  = qtys_ff[0] - cmd.amount;

   // keep: valid entries of equal or better price; a prefix since the book is sorted
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (CW'(i) < count_ff) &&
                   (IS_BID ? (prices_ff[i] >= cmd.price) : (prices_ff[i] <= cmd.price));
      end
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         ids_in[i]    = ids_ff[i];
         prices_in[i] = prices_ff[i];
         qtys_in[i]   = qtys_ff[i];
      end
      if (cmd.fill) begin
         if (front_left == '0) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               ids_in[i]    = ids_ff[i+1];
               prices_in[i] = prices_ff[i+1];
               qtys_in[i]   = qtys_ff[i+1];
            end
            count_in = count_ff - CW'(1);
         end else begin
            qtys_in[0] = front_left;
         end
      end else if (cmd.insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (!keep[i]) begin
               if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
                  ids_in[i]    = cmd.id;
                  prices_in[i] = cmd.price;
                  qtys_in[i]   = cmd.qty;
               end else begin
                  ids_in[i]    = ids_ff[(i == 0) ? 0 : i-1];
                  prices_in[i] = prices_ff[(i == 0) ? 0 : i-1];
                  qtys_in[i]   = qtys_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ids_ff[i]    <= ids_in[i];
         prices_ff[i] <= prices_in[i];
         qtys_ff[i]   <= qtys_in[i];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

// File: rtl/core/lobm_datapath.sv
// Datapath: order registers, both books and the result register.
module lobm_datapath #(
   parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lobm_pkg::dp_cmd_type          cmd,
   output lobm_pkg::dp_status_type       status,
   input  logic [lobm_pkg::ID_W-1:0]     req_order_id,
   input  logic                          req_side,
   input  logic                          req_is_limit,
   input  logic [lobm_pkg::PRICE_W-1:0]  req_limit_price,
   input  logic [lobm_pkg::QTY_W-1:0]    req_order_quantity,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [lobm_pkg::ID_W-1:0]     rsp_buyer_id,
   output logic [lobm_pkg::ID_W-1:0]     rsp_seller_id,
   output logic [lobm_pkg::PRICE_W-1:0]  rsp_trade_price,
   output logic [lobm_pkg::QTY_W-1:0]    rsp_amount,
   output logic [1:0]                    rsp_outcome,
   output logic                          rsp_last
);
   import lobm_pkg::*;

   logic [ID_W-1:0]    id_ff;
   logic               side_ff;
   logic               limit_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff, qty_in;

   logic               valid_ff, valid_in;
   logic               kind_ff, kind_in;
   logic [ID_W-1:0]    buyer_ff, buyer_in, seller_ff, seller_in;
   logic [PRICE_W-1:0] tprice_ff, tprice_in;
   logic [QTY_W-1:0]   amount_ff, amount_in;
   logic [1:0]         outcome_ff, outcome_in;

   book_cmd_type       bid_cmd, ask_cmd;
   logic [ID_W-1:0]    bid_id, ask_id, opp_id;
   logic [PRICE_W-1:0] bid_price, ask_price, opp_price;
   logic [QTY_W-1:0]   bid_qty, ask_qty, opp_qty, fill_qty;
   logic               bid_empty, ask_empty, bid_full, ask_full, own_full;
   logic               is_sell, do_rest;

   assign is_sell   = (side_ff != SIDE_BUY);
   assign opp_id    = is_sell ? bid_id : ask_id;
   assign opp_price = is_sell ? bid_price : ask_price;
   assign opp_qty   = is_sell ? bid_qty : ask_qty;
   assign own_full  = is_sell ? ask_full : bid_full;
   assign fill_qty  = (qty_ff < opp_qty) ? qty_ff : opp_qty;
   assign do_rest   = cmd.finish && (qty_ff != '0) && (limit_ff == ORDER_LIMIT) && !own_full;

   assign status.qty_zero  = (qty_ff == '0);
   assign status.opp_empty = is_sell ? bid_empty : ask_empty;
   assign status.price_ok  = (limit_ff != ORDER_LIMIT) ||
                             (is_sell ? (price_ff <= opp_price) : (price_ff >= opp_price));
   assign status.out_free  = !valid_ff || !rsp_stall;

   always_comb begin
      bid_cmd        = '0;
      bid_cmd.amount = fill_qty;
      bid_cmd.id     = id_ff;
      bid_cmd.price  = price_ff;
      bid_cmd.qty    = qty_ff;
      ask_cmd        = bid_cmd;
      bid_cmd.fill   = cmd.fill && is_sell;
      ask_cmd.fill   = cmd.fill && !is_sell;
      bid_cmd.insert = do_rest && !is_sell;
      ask_cmd.insert = do_rest && is_sell;
   end

   lobm_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b1)) u_bid (
      .clock, .reset, .cmd(bid_cmd), .front_id(bid_id), .front_price(bid_price),
      .front_qty(bid_qty), .empty(bid_empty), .full(bid_full)
   );
   lobm_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b0)) u_ask (
      .clock, .reset, .cmd(ask_cmd), .front_id(ask_id), .front_price(ask_price),
      .front_qty(ask_qty), .empty(ask_empty), .full(ask_full)
   );

   always_comb begin
      qty_in     = cmd.fill ? (qty_ff - fill_qty) : qty_ff;
      valid_in   = valid_ff && rsp_stall;
      kind_in    = kind_ff;
      buyer_in   = buyer_ff;
      seller_in  = seller_ff;
      tprice_in  = tprice_ff;
      amount_in  = amount_ff;
      outcome_in = outcome_ff;
      if (cmd.fill) begin
         valid_in   = 1'b1;
         kind_in    = KIND_TRADE;
         buyer_in   = is_sell ? opp_id : id_ff;
         seller_in  = is_sell ? id_ff : opp_id;
         tprice_in  = opp_price;
         amount_in  = fill_qty;
         outcome_in = OUTCOME_FILLED;
      end else if (cmd.finish) begin
         valid_in   = 1'b1;
         kind_in    = KIND_DONE;
         buyer_in   = id_ff;
         seller_in  = id_ff;
         tprice_in  = '0;
         amount_in  = qty_ff;
         priority if (qty_ff == '0)            outcome_in = OUTCOME_FILLED;
         else if (limit_ff != ORDER_LIMIT)     outcome_in = OUTCOME_DROPPED;
         else if (!own_full)                   outcome_in = OUTCOME_RESTED;
         else                                  outcome_in = OUTCOME_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff    <= req_order_id;
         side_ff  <= req_side;
         limit_ff <= req_is_limit;
         price_ff <= req_limit_price;
         qty_ff   <= req_order_quantity;
      end else begin
         qty_ff   <= qty_in;
      end
      kind_ff    <= kind_in;
      buyer_ff   <= buyer_in;
      seller_ff  <= seller_in;
      tprice_ff  <= tprice_in;
      amount_ff  <= amount_in;
      outcome_ff <= outcome_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_buyer_id    = buyer_ff;
   assign rsp_seller_id   = seller_ff;
   assign rsp_trade_price = tprice_ff;
   assign rsp_amount      = amount_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_last        = (kind_ff == KIND_DONE);
endmodule

// File: rtl/core/lobm_ctrl.sv
// Controller: accepts an order, steps fills, then issues the completion beat.
module lobm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lobm_pkg::dp_status_type  status,
   output lobm_pkg::dp_cmd_type     cmd
);
   import lobm_pkg::*;
   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MATCH = 1'b1;

   logic state_ff, state_in;
   logic can_fill;

   assign req_stall = (state_ff != ST_IDLE);
   assign can_fill  = !status.qty_zero && !status.opp_empty && status.price_ok;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (status.out_free) begin
               if (can_fill) begin
                  cmd.fill = 1'b1;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: rtl/core/limit_order_book_matcher_core.sv
// Limit order book matcher: price-time priority, top level.
// Steps: the order is taken, then one trade beat per fill, then a completion beat.
// Beats wait while results stall; no new order is taken before the completion beat issues.
// The result register lets a new order in while the last beat still waits.
// Reset (synchronous): both books empty, no beat pending; entries are not cleared.
module limit_order_book_matcher_core #(
   parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lobm_pkg::ID_W-1:0]     req_order_id,
   input  logic                          req_side,
   input  logic                          req_is_limit,
   input  logic [lobm_pkg::PRICE_W-1:0]  req_limit_price,
   input  logic [lobm_pkg::QTY_W-1:0]    req_order_quantity,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [lobm_pkg::ID_W-1:0]     rsp_buyer_id,
   output logic [lobm_pkg::ID_W-1:0]     rsp_seller_id,
   output logic [lobm_pkg::PRICE_W-1:0]  rsp_trade_price,
   output logic [lobm_pkg::QTY_W-1:0]    rsp_amount,
   output logic [1:0]                    rsp_outcome,
   output logic                          rsp_last
);
   import lobm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lobm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .status, .cmd
   );

   lobm_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_order_id, .req_side, .req_is_limit, .req_limit_price, .req_order_quantity,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_buyer_id, .rsp_seller_id,
      .rsp_trade_price, .rsp_amount, .rsp_outcome, .rsp_last
   );
endmodule

// File: rtl/core/lobm_checker.sv
// Port checker for the matcher, bound to the top level.
module lobm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [31:0] rsp_buyer_id,
   input logic [31:0] rsp_seller_id,
   input logic [1:0]  rsp_outcome,
   input logic        rsp_last
);
   a_last_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == rsp_kind)) else $error("last does not mark completion");
   a_trade_outcome: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_outcome == 2'd0)) else $error("trade with outcome");
   a_done_ids: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_buyer_id == rsp_seller_id))
      else $error("completion ids differ");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("stalled beat dropped");
endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_kind, .rsp_buyer_id, .rsp_seller_id,
   .rsp_outcome, .rsp_last
);

// File: test/lobm_checker.sv
// Scoreboard for the order book matcher: book model, expected beats and comparison.
`timescale 1ns / 1ps
module lobm_scoreboard
   import lobm_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [ID_W-1:0]    req_order_id,
   input  logic               req_side,
   input  logic               req_is_limit,
   input  logic [PRICE_W-1:0] req_limit_price,
   input  logic [QTY_W-1:0]   req_order_quantity,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_kind,
   input  logic [ID_W-1:0]    rsp_buyer_id,
   input  logic [ID_W-1:0]    rsp_seller_id,
   input  logic [PRICE_W-1:0] rsp_trade_price,
   input  logic [QTY_W-1:0]   rsp_amount,
   input  logic [1:0]         rsp_outcome,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending_beats,
   output int                 bid_depth,
   output int                 ask_depth,
   output int                 trade_total,
   output int                 full_total
);
   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    buyer;
      logic [ID_W-1:0]    seller;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   amount;
      logic [1:0]         outcome;
      logic               last;
   } beat_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } entry_type;

   localparam int BIDS      = 0;
   localparam int ASKS      = 1;
   localparam int EXP_DEPTH = 256;

   entry_type book [2][DEPTH];
   int        book_n [2] = '{0, 0};
   beat_type  exp_fifo [EXP_DEPTH];
   int        exp_rd = 0;
   int        exp_wr = 0;
   int        exp_n  = 0;

   assign pending_beats = exp_n;
   assign bid_depth = book_n[BIDS];
   assign ask_depth = book_n[ASKS];

   task automatic expect_beat(input beat_type b);
      exp_fifo[exp_wr] = b;
      exp_wr = (exp_wr + 1) % EXP_DEPTH;
      exp_n++;
   endtask

   // Fill the opposite book, then rest, drop or reject what is left.
   task automatic match_order(input logic [ID_W-1:0] id, input logic sell, input logic lim,
                              input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qty_in);
      logic [QTY_W-1:0] qty;
      logic [QTY_W-1:0] fill;
      logic [1:0]       oc;
      entry_type        top;
      int               opp;
      int               own;
      int               pos;
      int               k;
      beat_type         b;
      opp = sell ? BIDS : ASKS;
      own = sell ? ASKS : BIDS;
      qty = qty_in;
      while (qty != 0 && book_n[opp] != 0) begin
         top = book[opp][0];
         if (lim == ORDER_LIMIT && (sell ? px > top.price : px < top.price)) break;
         fill = (qty < top.qty) ? qty : top.qty;
         b = '{KIND_TRADE, sell ? top.id : id, sell ? id : top.id, top.price, fill,
               OUTCOME_FILLED, 1'b0};
         expect_beat(b);
         trade_total++;
         qty -= fill;
         top.qty -= fill;
         if (top.qty == 0) begin
            for (k = 1; k < book_n[opp]; k++) book[opp][k-1] = book[opp][k];
            book_n[opp]--;
         end else begin
            book[opp][0] = top;
         end
      end
      if (qty == 0) oc = OUTCOME_FILLED;
      else if (lim != ORDER_LIMIT) oc = OUTCOME_DROPPED;
      else if (book_n[own] >= DEPTH) begin
         oc = OUTCOME_FULL;
         full_total++;
      end else begin
         oc = OUTCOME_RESTED;
         pos = 0;
         while (pos < book_n[own] &&
                (sell ? book[own][pos].price <= px : book[own][pos].price >= px)) pos++;
         for (k = book_n[own]; k > pos; k--) book[own][k] = book[own][k-1];
         book[own][pos] = '{id, px, qty};
         book_n[own]++;
      end
      b = '{KIND_DONE, id, id, '0, qty, oc, 1'b1};
      expect_beat(b);
   endtask

   always @(posedge clock) begin
      beat_type got;
      beat_type exp_b;
      if (reset) begin
         fail_count <= 0;
         trade_total = 0;
         full_total = 0;
         book_n[BIDS] = 0;
         book_n[ASKS] = 0;
         exp_rd = 0;
         exp_wr = 0;
         exp_n = 0;
      end else begin
         if (req_valid && !req_stall)
            match_order(req_order_id, req_side, req_is_limit, req_limit_price,
                        req_order_quantity);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_buyer_id, rsp_seller_id, rsp_trade_price, rsp_amount,
                    rsp_outcome, rsp_last};
            if (exp_n == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_b = exp_fifo[exp_rd];
               exp_rd = (exp_rd + 1) % EXP_DEPTH;
               exp_n--;
               if (got !== exp_b) begin
                  if (fail_count < 10) begin
                     $display("exp kind %0d buy %h sell %h px %0d amt %0d oc %0d last %0d",
                        exp_b.kind, exp_b.buyer, exp_b.seller, exp_b.price, exp_b.amount,
                        exp_b.outcome, exp_b.last);
                     $display("got kind %0d buy %h sell %h px %0d amt %0d oc %0d last %0d",
                        got.kind, got.buyer, got.seller, got.price, got.amount,
                        got.outcome, got.last);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: test/tb_limit_order_book_matcher_core.sv
// Testbench top for the order book matcher: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_limit_order_book_matcher_core;
   import lobm_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [ID_W-1:0]    req_order_id = '0;
   logic               req_side = 1'b0;
   logic               req_is_limit = 1'b0;
   logic [PRICE_W-1:0] req_limit_price = '0;
   logic [QTY_W-1:0]   req_order_quantity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic               rsp_kind;
   logic [ID_W-1:0]    rsp_buyer_id;
   logic [ID_W-1:0]    rsp_seller_id;
   logic [PRICE_W-1:0] rsp_trade_price;
   logic [QTY_W-1:0]   rsp_amount;
   logic [1:0]         rsp_outcome;
   logic               rsp_last;
   int fail_count, pending_beats, bid_depth, ask_depth, trade_total, full_total;
   int cycle_count = 0;
   int order_count = 0;
   bit calm = 0;        // no idling on either side
   bit hold_rsp = 0;    // long receiver hold-off

   always #1 clock = ~clock;

   limit_order_book_matcher_core dut (.*);

   lobm_scoreboard #(.DEPTH(32)) u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
   end

   // One order beat, with random idle gaps unless in the calm stretch.
   // Valid stays up on return; callers drop it before pausing.
   task automatic send_order(input logic [ID_W-1:0] id, input logic side, input logic lim,
                             input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qty);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_order_id <= id;
      req_side <= side;
      req_is_limit <= lim;
      req_limit_price <= px;
      req_order_quantity <= qty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      order_count++;
      @(negedge clock);
   endtask

   task automatic send_random(input int mode);
      logic [PRICE_W-1:0] px;
      logic [QTY_W-1:0]   qty;
      int r;
      r = $urandom_range(99);
      px = (r < 5) ? 16'($urandom_range(65535, 0)) : 16'(1000 + $urandom_range(20));
      qty = (r < 8) ? 24'($urandom) : 24'($urandom_range(1, 60));
      if (r > 96) qty = 0;
      if (mode == 1) qty = 24'($urandom_range(1, 3));
      send_order($urandom, 1'($urandom_range(1)), ($urandom_range(9) != 0), px, qty);
   endtask

   initial begin
      int i;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: empty book, extremes, zero quantity, market drop, price stop
      send_order(32'h0, SIDE_BUY, ORDER_MARKET, 16'd0, 24'd5);
      send_order(32'hFFFF_FFFF, SIDE_SELL, ORDER_LIMIT, 16'hFFFF, 24'hFF_FFFF);
      send_order(32'h1, SIDE_BUY, ORDER_LIMIT, 16'd0, 24'd0);
      send_order(32'h2, SIDE_BUY, ORDER_LIMIT, 16'hFFFE, 24'd7);
      send_order(32'h3, SIDE_BUY, ORDER_LIMIT, 16'hFFFF, 24'd10);
      send_order(32'h4, SIDE_BUY, ORDER_LIMIT, 16'd0, 24'd1);
      send_order(32'h5, SIDE_SELL, ORDER_LIMIT, 16'd1, 24'd3);
      send_order(32'h6, SIDE_SELL, ORDER_MARKET, 16'hFFFF, 24'd12);
      send_order(32'h7, SIDE_SELL, ORDER_MARKET, 16'd0, 24'd20);
      send_order(32'hAAAA_5555, SIDE_BUY, ORDER_MARKET, 16'h5555, 24'hFF_FFFF);
      send_order(32'h5555_AAAA, SIDE_BUY, ORDER_MARKET, 16'hAAAA, 24'hAA_AAAA);
      send_order(32'h8, SIDE_SELL, ORDER_LIMIT, 16'h8000, 24'h55_5555);
      // fill the bid book past depth: many tiny bids, one big sweep later
      for (i = 0; i < 34; i++)
         send_order(32'h100 + i, SIDE_BUY, ORDER_LIMIT, 16'(10 + (i % 5)), 24'd1);
      // receiver hold-off while orders keep coming
      hold_rsp = 1;
      fork
         begin repeat (300) @(negedge clock); hold_rsp = 0; end
         begin
            for (i = 0; i < 6; i++) send_random(1);
            req_valid <= 1'b0;
            @(negedge clock);
         end
      join
      // sweep the whole bid book in one order
      send_order(32'h200, SIDE_SELL, ORDER_MARKET, 16'd0, 24'd100);
      // sender pause until drained
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_beats != 0) @(negedge clock);
      calm = 1;
      for (i = 0; i < 40; i++) send_random(0);
      calm = 0;
      for (i = 0; i < 117; i++) send_random((i % 3 == 0) ? 1 : 0);
      req_valid <= 1'b0;
      while (pending_beats != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("orders %0d, trades %0d, book-full rejects %0d, final depths bid %0d ask %0d",
               order_count, trade_total, full_total, bid_depth, ask_depth);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
